>>> rtl/rrt_pkg.sv
// Shared types and operation codes for the relay route table.
// No dependencies; used by rrt_cell and relay_route_table.
package rrt_pkg;

   localparam int TABLE_DEPTH_DEF = 16;
   localparam int HASH_W = 64;

   localparam logic [1:0] FUNC_LOOKUP = 2'd0;
   localparam logic [1:0] FUNC_UPDATE = 2'd1;
   localparam logic [1:0] FUNC_INVAL  = 2'd2;

   typedef struct packed {
      logic [1:0]        func;
      logic [HASH_W-1:0] dst_hash;
      logic [HASH_W-1:0] owner_hash;
      logic [HASH_W-1:0] hop_in;
   } rrt_req_type;

   typedef struct packed {
      logic [HASH_W-1:0] hop_out;
      logic              hit;
      logic              full_res;
   } rrt_rsp_type;

   // transaction as it walks the cell chain
   typedef struct packed {
      logic              vld;
      rrt_req_type       req;
      logic              done;
      logic              hit;
      logic [HASH_W-1:0] hop;
   } rrt_tx_type;

endpackage

>>> rtl/rrt_cell.sv
// One route slot of the relay route table plus its transaction stage register.
// Depends on rrt_pkg.
module rrt_cell (
   input  logic               clock,
   input  logic               reset,
   input  logic               advance,
   input  rrt_pkg::rrt_tx_type up_tx,
   output rrt_pkg::rrt_tx_type down_tx
);
   import rrt_pkg::*;

   logic              used_ff, used_in;
   logic              valid_ff, valid_in;
   logic [HASH_W-1:0] dst_ff, dst_in;
   logic [HASH_W-1:0] owner_ff, owner_in;
   logic [HASH_W-1:0] hop_ff, hop_in;
   rrt_tx_type        tx_ff, tx_in;
   rrt_tx_type        work;
   logic              dst_match;
   logic              owner_match;

   assign dst_match   = used_ff && (dst_ff == up_tx.req.dst_hash);
   assign owner_match = used_ff && (owner_ff == up_tx.req.owner_hash);

   always_comb begin
      used_in  = used_ff;
      valid_in = valid_ff;
      dst_in   = dst_ff;
      owner_in = owner_ff;
      hop_in   = hop_ff;
      work     = up_tx;
      if (advance && up_tx.vld) begin
         unique case (up_tx.req.func)
            FUNC_LOOKUP: begin
               if (dst_match && valid_ff) begin
                  work.hop = hop_ff;
                  work.hit = 1'b1;
               end
            end
            FUNC_UPDATE: begin
               if (!up_tx.done) begin
                  if (dst_match) begin
                     hop_in    = up_tx.req.hop_in;
                     valid_in  = 1'b1;
                     work.hit  = 1'b1;
                     work.done = 1'b1;
                  end else if (!used_ff) begin
                     // slots fill in order, so the first free slot ends the search
                     used_in   = 1'b1;
                     valid_in  = 1'b1;
                     dst_in    = up_tx.req.dst_hash;
                     owner_in  = up_tx.req.owner_hash;
                     hop_in    = up_tx.req.hop_in;
                     work.done = 1'b1;
                  end
               end
            end
            FUNC_INVAL: begin
               if (owner_match) begin
                  valid_in = 1'b0;
               end
            end
            default: begin
            end
         endcase
      end
      tx_in = advance ? work : tx_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff    <= 1'b0;
         valid_ff   <= 1'b0;
         tx_ff.vld  <= 1'b0;
      end else begin
         used_ff    <= used_in;
         valid_ff   <= valid_in;
         tx_ff.vld  <= tx_in.vld;
      end
      dst_ff     <= dst_in;
      owner_ff   <= owner_in;
      hop_ff     <= hop_in;
      tx_ff.req  <= tx_in.req;
      tx_ff.done <= tx_in.done;
      tx_ff.hit  <= tx_in.hit;
      tx_ff.hop  <= tx_in.hop;
   end

   assign down_tx = tx_ff;

endmodule

>>> rtl/relay_route_table.sv
// Relay route table: a chain of TABLE_DEPTH route cells; a transaction visits one cell per cycle.
// A request passes through every cell stage register and then the response register before rsp_valid rises.
// Only one transaction is in the chain at a time: req_ready stays low from accept until its response is loaded.
// Reset clears all used and valid marks, so the table starts empty with no clearing pass.
// Depends on rrt_pkg and rrt_cell.
module relay_route_table #(
   parameter int TABLE_DEPTH = rrt_pkg::TABLE_DEPTH_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  rrt_pkg::rrt_req_type req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output rrt_pkg::rrt_rsp_type rsp_data
);
   import rrt_pkg::*;

   rrt_tx_type  chain [TABLE_DEPTH+1];
   rrt_tx_type  last_tx;
   logic        advance;
   logic        out_load;
   logic        busy_ff, busy_in;
   logic        rsp_valid_ff, rsp_valid_in;
   rrt_rsp_type rsp_ff, rsp_in;

   assign req_ready = !busy_ff;

   always_comb begin
      chain[0]          = '0;
      chain[0].vld      = req_valid && req_ready;
      chain[0].req      = req_data;
   end

   for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
      rrt_cell u_cell (
         .clock   (clock),
         .reset   (reset),
         .advance (advance),
         .up_tx   (chain[g]),
         .down_tx (chain[g+1])
      );
   end

   assign last_tx  = chain[TABLE_DEPTH];
   assign out_load = last_tx.vld && (!rsp_valid_ff || rsp_ready);
   assign advance  = !last_tx.vld || out_load;

   always_comb begin
      busy_in      = busy_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (req_valid && req_ready) begin
         busy_in = 1'b1;
      end
      if (out_load) begin
         busy_in         = 1'b0;
         rsp_valid_in    = 1'b1;
         rsp_in.hop_out  = (last_tx.req.func == FUNC_LOOKUP) ? last_tx.hop : '0;
         rsp_in.hit      = last_tx.hit;
         rsp_in.full_res = (last_tx.req.func == FUNC_UPDATE) && !last_tx.done;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

>>> verif/relay_route_table_tb.sv
// Self-checking testbench for relay_route_table: lookup, update/insert, invalidate by owner.
// A clocked driver and monitor with random idling, a route-table predictor and a response queue.
// Depends on rrt_pkg and the relay_route_table RTL.
module relay_route_table_tb;
   import rrt_pkg::*;

   localparam int DEPTH = TABLE_DEPTH_DEF;
   localparam int LAT = DEPTH + 1;
   localparam int LIMIT = 400000;
   localparam int N_RANDOM = 1335;
   localparam int N_KEYS = 22;
   localparam int N_OWNERS = 4;
   localparam logic [1:0] FUNC_UNUSED = 2'd3;
   localparam logic [63:0] ALL_ONES = {64{1'b1}};

   typedef struct packed {
      logic        drain;
      rrt_req_type req;
   } pend_type;

   logic        clock;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   rrt_req_type req_data = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   rrt_rsp_type rsp_data;

   pend_type    stim_q[$];
   rrt_rsp_type route_exp_q[$];

   // predictor copy of the table
   logic        tbl_used[DEPTH];
   logic        tbl_valid[DEPTH];
   logic [63:0] tbl_dst[DEPTH];
   logic [63:0] tbl_owner[DEPTH];
   logic [63:0] tbl_hop[DEPTH];

   logic [63:0] key_pool[N_KEYS];
   logic [63:0] owner_pool[N_OWNERS];

   int n_sent = 0;
   int n_recv = 0;
   int n_err = 0;
   int n_hit = 0;
   int n_insert = 0;
   int n_full = 0;
   int n_inval = 0;
   int hold_left = 0;
   bit hold_done = 1'b0;
   int cycle_cnt = 0;

   relay_route_table DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always begin
      clock = 1'b1;
      #1;
      clock = 1'b0;
      #1;
   end

   function automatic rrt_rsp_type route_predict(rrt_req_type r);
      rrt_rsp_type o;
      int idx;
      o = '0;
      idx = -1;
      for (int i = 0; i < DEPTH; i++) begin
         if (idx < 0 && tbl_used[i] && tbl_dst[i] == r.dst_hash) idx = i;
      end
      case (r.func)
         FUNC_LOOKUP: begin
            if (idx >= 0 && tbl_valid[idx]) begin
               o.hop_out = tbl_hop[idx];
               o.hit = 1'b1;
               n_hit++;
            end
         end
         FUNC_UPDATE: begin
            if (idx >= 0) begin
               tbl_hop[idx] = r.hop_in;
               tbl_valid[idx] = 1'b1;
               o.hit = 1'b1;
               n_hit++;
            end else begin
               for (int i = 0; i < DEPTH; i++) begin
                  if (idx < 0 && !tbl_used[i]) idx = i;
               end
               if (idx >= 0) begin
                  tbl_used[idx] = 1'b1;
                  tbl_valid[idx] = 1'b1;
                  tbl_dst[idx] = r.dst_hash;
                  tbl_owner[idx] = r.owner_hash;
                  tbl_hop[idx] = r.hop_in;
                  n_insert++;
               end else begin
                  o.full_res = 1'b1;
                  n_full++;
               end
            end
         end
         FUNC_INVAL: begin
            n_inval++;
            for (int i = 0; i < DEPTH; i++) begin
               if (tbl_used[i] && tbl_owner[i] == r.owner_hash) tbl_valid[i] = 1'b0;
            end
         end
         default: ;
      endcase
      return o;
   endfunction

   task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      n_err++;
      $display("mismatch at response %0d: %s got %h want %h", n_recv, what, got, want);
   endtask

   task automatic add_item(logic [1:0] f, logic [63:0] dst, logic [63:0] own,
                           logic [63:0] hop, logic drain = 1'b0);
      pend_type p;
      p.drain = drain;
      p.req.func = f;
      p.req.dst_hash = dst;
      p.req.owner_hash = own;
      p.req.hop_in = hop;
      stim_q.push_back(p);
   endtask

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   // driver
   always @(posedge clock) begin
      bit free;
      bit offer;
      int sent_now;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         sent_now = n_sent;
         if (req_valid && req_ready) begin
            route_exp_q.push_back(route_predict(req_data));
            sent_now++;
            n_sent <= sent_now;
         end
         free = !req_valid || req_ready;
         if (free) begin
            offer = stim_q.size() != 0;
            if (offer && stim_q[0].drain && n_recv != sent_now) offer = 0;
            if (offer && !(sent_now >= 500 && sent_now < 750) && $urandom_range(99) < 16)
               offer = 0;
            if (offer) begin
               req_data <= stim_q[0].req;
               stim_q.pop_front();
            end
            req_valid <= offer;
         end
      end
   end

   // long receiver hold-off
   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
         hold_done <= 1'b0;
      end else if (!hold_done && n_recv == 300) begin
         hold_left <= 400;
         hold_done <= 1'b1;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
      end
   end

   // monitor
   always @(posedge clock) begin
      rrt_rsp_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (route_exp_q.size() == 0) begin
               report_mismatch("unexpected response, hop_out", rsp_data.hop_out, '0);
            end else begin
               want = route_exp_q.pop_front();
               if (rsp_data.hop_out !== want.hop_out)
                  report_mismatch("hop_out", rsp_data.hop_out, want.hop_out);
               if (rsp_data.hit !== want.hit)
                  report_mismatch("hit", 64'(rsp_data.hit), 64'(want.hit));
               if (rsp_data.full_res !== want.full_res)
                  report_mismatch("full_res", 64'(rsp_data.full_res), 64'(want.full_res));
            end
            n_recv <= n_recv + 1;
         end
         rsp_ready <= hold_left == 0 &&
                      ((n_recv >= 500 && n_recv < 750) || $urandom_range(99) >= 16);
      end
   end

   always @(posedge clock) begin
      cycle_cnt <= cycle_cnt + 1;
      if (cycle_cnt == LIMIT) begin
         $display("[relay_route_table] ERROR");
         $finish;
      end
   end

   initial begin
      int r;
      logic [1:0] f;
      logic [63:0] dst;
      logic [63:0] own;
      logic [63:0] hop;
      for (int i = 0; i < DEPTH; i++) begin
         tbl_used[i] = 1'b0;
         tbl_valid[i] = 1'b0;
         tbl_dst[i] = '0;
         tbl_owner[i] = '0;
         tbl_hop[i] = '0;
      end
      key_pool[0] = '0;
      key_pool[1] = ALL_ONES;
      key_pool[2] = 64'h8000_0000_0000_0000;
      key_pool[3] = 64'h1;
      for (int i = 4; i < N_KEYS; i++) key_pool[i] = rand64();
      owner_pool[0] = '0;
      owner_pool[1] = ALL_ONES;
      owner_pool[2] = rand64();
      owner_pool[3] = rand64();

      // directed: empty table, insert, hop of zero, rewrite, invalidate, revalidate
      add_item(FUNC_LOOKUP, '0, '0, '0);
      add_item(FUNC_UPDATE, '0, ALL_ONES, ALL_ONES);
      add_item(FUNC_LOOKUP, '0, '0, '0);
      add_item(FUNC_UPDATE, ALL_ONES, '0, '0);
      add_item(FUNC_LOOKUP, ALL_ONES, ALL_ONES, ALL_ONES);
      add_item(FUNC_UPDATE, '0, 64'h5555_5555_5555_5555, 64'hA5A5_A5A5_A5A5_A5A5);
      add_item(FUNC_LOOKUP, '0, '0, '0);
      add_item(FUNC_INVAL, '0, ALL_ONES, '0);
      add_item(FUNC_LOOKUP, '0, '0, '0);
      add_item(FUNC_INVAL, ALL_ONES, 64'h1234, ALL_ONES);
      add_item(FUNC_UPDATE, '0, 64'h7777, 64'h0123_4567_89AB_CDEF);
      add_item(FUNC_LOOKUP, '0, '0, '0);
      add_item(FUNC_UNUSED, ALL_ONES, ALL_ONES, ALL_ONES);
      add_item(FUNC_LOOKUP, '0, '0, '0);
      add_item(FUNC_INVAL, '0, '0, '0);
      add_item(FUNC_LOOKUP, ALL_ONES, '0, '0);
      add_item(FUNC_UPDATE, ALL_ONES, ALL_ONES, 64'hFEDC_BA98_7654_3210);
      add_item(FUNC_LOOKUP, ALL_ONES, '0, '0);
      add_item(FUNC_LOOKUP, 64'h8000_0000_0000_0000, '0, '0);

      // random: keys mostly from a small pool so the table fills and overflows
      for (int n = 0; n < N_RANDOM; n++) begin
         r = $urandom_range(99);
         if (r < 40) f = FUNC_LOOKUP;
         else if (r < 75) f = FUNC_UPDATE;
         else if (r < 90) f = FUNC_INVAL;
         else if (r < 93) f = FUNC_UNUSED;
         else f = FUNC_LOOKUP;
         dst = (r >= 93 || $urandom_range(9) == 0) ? rand64()
                                                   : key_pool[$urandom_range(N_KEYS - 1)];
         own = ($urandom_range(7) == 0) ? rand64()
                                        : owner_pool[$urandom_range(N_OWNERS - 1)];
         case ($urandom_range(9))
            0: hop = '0;
            1: hop = ALL_ONES;
            default: hop = rand64();
         endcase
         add_item(f, dst, own, hop, n == 600 || n == 1000);
      end

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      while (stim_q.size() != 0 || req_valid) @(posedge clock);
      while (n_recv != n_sent) @(posedge clock);
      repeat (LAT + 8) @(posedge clock);
      if (route_exp_q.size() != 0)
         report_mismatch("responses missing", 64'(route_exp_q.size()), '0);

      $display("covered %0d transactions: %0d hits, %0d inserts, %0d dropped on full table,",
               n_sent, n_hit, n_insert, n_full);
      $display("%0d invalidates, with random idling and a long response hold-off", n_inval);
      if (n_err == 0) begin
         $display("[relay_route_table] OK");
      end else begin
         $display("[relay_route_table] ERROR");
      end
      $finish;
   end

endmodule
